FILE: rtl/prefix_code_bit_packer_macros.svh
// Assertion macros used by the checker of the bit packer.
`ifndef PREFIX_CODE_BIT_PACKER_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_MACROS_SVH

// Property checked at every rising clock edge, also while reset is applied.
`define PCBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only outside reset.
`define PCBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/pcbp_pkg.sv
package pcbp_pkg;

    // Field widths of the beats.
    localparam int KIND_W   = 2;
    localparam int SYMBOL_W = 8;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;

    // Table size and longest code.
    localparam int SYMBOL_COUNT  = 256;
    localparam int MAX_CODE_BITS = 32;

    // Derived sizes.
    localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int STORED_LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + MAX_CODE_BITS;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int MAX_BYTES    = (MAX_CODE_BITS + PEND_W) / BYTE_W;
    localparam int CNT_W        = $clog2(MAX_BYTES + 1);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SYMBOL_W-1:0] symbol;
        logic [WORD_W-1:0]   code_word;
        logic [LEN_W-1:0]    code_length;
    } sym_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } byte_beat_t;

endpackage

FILE: rtl/prefix_code_bit_packer.sv
// Prefix-code bit packer: back end of a table-driven Huffman encoder.
//
// The sym channel carries items: a load beat writes one table entry (code
// word and length, saturated to 32 bits), an encode beat appends the code of
// its symbol to the pending bits, and a flush beat emits the partial byte,
// left-aligned with zero padding. The byte channel carries the packed bytes,
// earliest bit in bit 7; last marks the final byte caused by one item.
//
// One item is accepted per cycle while the sym channel is not stalled. The
// table lives in a synchronous memory read at accept time; the merge stage
// then merges the code into the pending bits with barrel shifts, once the
// output buffer is free, and loads up to four bytes into it. The first
// byte of an item is shown once the merge stage has loaded the buffer. The
// byte port moves one byte per cycle while the receiver does not stall, and
// the sym channel stalls only while an item waits for the buffer to drain.
//
// Reset clears the pending bits and the pipeline; the table is not cleared
// and an entry must be loaded before it is encoded. When the receiver stalls
// the current byte holds, one item waits in the merge stage, and then the
// sym channel stalls.
module prefix_code_bit_packer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sym_valid,
    output logic                   sym_stall,
    input  pcbp_pkg::sym_beat_t    sym_data,
    output logic                   byte_valid,
    input  logic                   byte_stall,
    output pcbp_pkg::byte_beat_t   byte_data
);
    import pcbp_pkg::*;

    // Table memories.
    logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
    logic [STORED_LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
    logic [MAX_CODE_BITS-1:0] rd_code_reg;
    logic [STORED_LEN_W-1:0]  rd_len_reg;

    // Merge stage.
    logic              s1_valid_reg, s1_valid_next;
    logic [KIND_W-1:0] s1_kind_reg;
    logic              s1_sym_ok_reg;

    // Pending bits.
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    // Output buffer: a short shift line, byte 0 is on the port.
    logic [BYTE_W-1:0] ob_bytes_reg  [MAX_BYTES];
    logic [BYTE_W-1:0] ob_bytes_next [MAX_BYTES];
    logic [CNT_W-1:0]  ob_rem_reg, ob_rem_next;

    logic                     accept;
    logic                     out_beat;
    logic                     buf_free;
    logic                     s1_advance;
    logic                     sym_ok;
    logic [IDX_W-1:0]         addr;
    logic [STORED_LEN_W-1:0]  len_sat;
    logic [MAX_CODE_BITS-1:0] code_masked;
    logic [ACC_W-1:0]         acc;
    logic [ACC_W-1:0]         aligned;
    logic [TOT_W-1:0]         total;
    logic [CNT_W-1:0]         enc_count;
    logic [BYTE_W-1:0]        flush_byte;

    assign out_beat   = byte_valid && !byte_stall;
    assign buf_free   = (ob_rem_reg == '0) || ((ob_rem_reg == CNT_W'(1)) && out_beat);
    assign s1_advance = s1_valid_reg && buf_free;
    assign sym_stall  = s1_valid_reg && !buf_free;
    assign accept     = sym_valid && !sym_stall;

    assign byte_valid         = (ob_rem_reg != '0);
    assign byte_data.out_byte = ob_bytes_reg[0];
    assign byte_data.last     = (ob_rem_reg == CNT_W'(1));

    // Load path: saturate the length and drop code bits above it.
    assign sym_ok = ({1'b0, sym_data.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
    assign addr   = sym_data.symbol[IDX_W-1:0];
    assign len_sat = (sym_data.code_length > LEN_W'(MAX_CODE_BITS))
                   ? STORED_LEN_W'(MAX_CODE_BITS)
                   : sym_data.code_length[STORED_LEN_W-1:0];
    assign code_masked = sym_data.code_word[MAX_CODE_BITS-1:0]
                       & ~({MAX_CODE_BITS{1'b1}} << len_sat);

    // A load writes at its accept edge, so a following encode of the same
    // entry, read at its own later accept edge, already sees the new contents.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (sym_data.kind == KIND_LOAD && sym_ok)
            begin
                code_mem[addr] <= code_masked;
                len_mem[addr]  <= len_sat;
            end
            rd_code_reg <= code_mem[addr];
            rd_len_reg  <= len_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= sym_data.kind;
            s1_sym_ok_reg <= sym_ok;
        end
    end

    // Merge: pending bits followed by the code, then left-aligned so that
    // completed bytes sit at the top of the word.
    assign acc       = (ACC_W'(pend_bits_reg) << rd_len_reg) | ACC_W'(rd_code_reg);
    assign total     = TOT_W'(pend_cnt_reg) + TOT_W'(rd_len_reg);
    assign aligned   = acc << (TOT_W'(ACC_W) - total);
    assign enc_count = CNT_W'(total >> 3);
    assign flush_byte = BYTE_W'({pend_bits_reg, 1'b0} << (PCNT_W'(PEND_W) - pend_cnt_reg));

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        ob_rem_next    = ob_rem_reg;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            ob_bytes_next[k] = ob_bytes_reg[k];
        end

        // Drain one byte per beat.
        if (out_beat)
        begin
            ob_rem_next = ob_rem_reg - CNT_W'(1);
            for (int k = 0; k < MAX_BYTES - 1; k++)
            begin
                ob_bytes_next[k] = ob_bytes_reg[k + 1];
            end
        end

        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
            unique case (s1_kind_reg)
                KIND_ENCODE:
                begin
                    if (s1_sym_ok_reg)
                    begin
                        for (int k = 0; k < MAX_BYTES; k++)
                        begin
                            ob_bytes_next[k] = aligned[ACC_W - 1 - BYTE_W * k -: BYTE_W];
                        end
                        ob_rem_next    = enc_count;
                        pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
                        pend_cnt_next  = total[PCNT_W-1:0];
                    end
                end
                KIND_FLUSH:
                begin
                    if (pend_cnt_reg != '0)
                    begin
                        ob_bytes_next[0] = flush_byte;
                        ob_rem_next      = CNT_W'(1);
                        pend_bits_next   = '0;
                        pend_cnt_next    = '0;
                    end
                end
                default:
                begin
                    // Loads and the unused kind give no bytes.
                end
            endcase
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            ob_rem_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            ob_rem_reg    <= ob_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            ob_bytes_reg[k] <= ob_bytes_next[k];
        end
    end

endmodule

FILE: rtl/pcbp_checker.sv
`include "prefix_code_bit_packer_macros.svh"

module pcbp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sym_valid,
    input logic                 sym_stall,
    input logic                 byte_valid,
    input logic                 byte_stall,
    input pcbp_pkg::byte_beat_t byte_data
);
    import pcbp_pkg::*;

    // No byte is offered at the edge after one that saw reset applied.
    `PCBP_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !byte_valid, "byte offered in reset")

    // A stalled byte stays offered and unchanged.
    `PCBP_ASSERT(a_byte_hold, byte_valid && byte_stall |=> byte_valid && $stable(byte_data), "stalled byte changed")

    // The bytes of one item follow without a gap.
    `PCBP_ASSERT(a_no_gap, byte_valid && !byte_data.last && !byte_stall |=> byte_valid, "gap inside an item")

    // The sym side stalls only while the output buffer holds a byte.
    `PCBP_ASSERT(a_stall_cause, sym_stall |-> byte_valid, "input stalled with empty output")

    // After a stalled sym beat, sym stall must not be unknown.
    `PCBP_ASSERT(a_stall_known, sym_valid && sym_stall |=> !$isunknown(sym_stall), "stall unknown")

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (.*);
